// ----- rtl/pidaw_pkg.sv -----
package pidaw_pkg;

    // Field and register widths.
    localparam int VAL_W   = 16;
    localparam int GAIN_W  = 32;
    localparam int FRAC_W  = 16;
    localparam int IDX_W   = 3;
    localparam int DATA_W  = 32;

    // Error and measurement step are exact 17-bit integers.
    localparam int OPD_W   = VAL_W + 1;
    // Gain times operand, exact Q33.16.
    localparam int PROD_W  = GAIN_W + OPD_W;
    // Integrator plus integral term, and proportional minus derivative term.
    localparam int ISUM_W  = PROD_W + 1;
    localparam int PD_W    = PROD_W + 1;
    // Full output sum before saturation.
    localparam int Y_W     = PD_W + 1;
    // Integrator storage, Q16.16 within the 16-bit limits.
    localparam int INTEG_W = VAL_W + FRAC_W;

    // Configuration register indexes.
    typedef enum logic [IDX_W-1:0] {
        REG_KP      = 3'd0,
        REG_KI      = 3'd1,
        REG_KD      = 3'd2,
        REG_LOW     = 3'd3,
        REG_HIGH    = 3'd4,
        REG_REVERSE = 3'd5
    } cfg_reg_t;

    localparam logic signed [VAL_W-1:0] LOW_RESET  = 16'sh8000;
    localparam logic signed [VAL_W-1:0] HIGH_RESET = 16'sh7FFF;

endpackage

// ----- rtl/pid_controller_antiwindup.sv -----
// PID controller with anti-windup clamping and derivative on measurement.
// Each accepted item passes the stage 1, stage 2, stage 3 and output registers.
// Throughput: one item per cycle while out_stall is low; four register
// stages (input, multiply, integrator, output) advance independently, so
// bubbles close up under stall. Reset: all gains zero, limits at full 16-bit
// range, integrator and stored measurement zero, manual mode, pipeline empty.
module pid_controller_antiwindup
    import pidaw_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,

    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [IDX_W-1:0]         cfg_index,
    input  logic [DATA_W-1:0]        cfg_data,

    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic signed [VAL_W-1:0]  measurement,
    input  logic signed [VAL_W-1:0]  target,
    input  logic signed [VAL_W-1:0]  manual_output,
    input  logic                     auto_mode,

    output logic                     out_valid,
    input  logic                     out_stall,
    output logic signed [VAL_W-1:0]  drive_output,
    output logic                     computed
);

    // Configuration registers.
    logic signed [GAIN_W-1:0] kp_reg;
    logic signed [GAIN_W-1:0] ki_reg;
    logic signed [GAIN_W-1:0] kd_reg;
    logic signed [VAL_W-1:0]  low_reg;
    logic signed [VAL_W-1:0]  high_reg;
    logic                     reverse_reg;

    // Controller state.
    logic                      was_auto_reg;
    logic signed [VAL_W-1:0]   prev_meas_reg;
    logic signed [INTEG_W-1:0] integ_reg;
    logic signed [INTEG_W-1:0] integ_next;

    // Stage 1: captured item.
    logic                     v1_reg;
    logic signed [OPD_W-1:0]  err1_reg;
    logic signed [OPD_W-1:0]  dm1_reg;
    logic signed [VAL_W-1:0]  man1_reg;
    logic                     auto1_reg;
    logic                     load1_reg;

    // Stage 2: products.
    logic                     v2_reg;
    logic signed [PROD_W-1:0] pprod2_reg;
    logic signed [PROD_W-1:0] iprod2_reg;
    logic signed [PROD_W-1:0] dprod2_reg;
    logic signed [VAL_W-1:0]  man2_reg;
    logic signed [VAL_W-1:0]  manc2_reg;
    logic                     auto2_reg;
    logic                     load2_reg;

    // Stage 3: integrator updated, proportional and derivative combined.
    logic                     v3_reg;
    logic signed [PD_W-1:0]   pd3_reg;
    logic signed [VAL_W-1:0]  man3_reg;
    logic                     auto3_reg;

    // Output stage.
    logic                     out_valid_reg;
    logic signed [VAL_W-1:0]  drive_reg;
    logic                     computed_reg;

    logic en1;
    logic en2;
    logic en3;
    logic en_out;
    logic accept;

    logic signed [VAL_W-1:0]  lim_lo;
    logic signed [VAL_W-1:0]  lim_hi;

    logic signed [OPD_W-1:0]  err_raw;
    logic signed [OPD_W-1:0]  dm_raw;
    logic signed [OPD_W-1:0]  err_dir;
    logic signed [OPD_W-1:0]  dm_dir;
    logic signed [VAL_W-1:0]  man_clamped;

    logic signed [INTEG_W-1:0] integ_base;
    logic signed [ISUM_W-1:0]  integ_sum;
    logic signed [ISUM_W-1:0]  isum_lo;
    logic signed [ISUM_W-1:0]  isum_hi;

    logic signed [Y_W-1:0]    y_sum;
    logic signed [Y_W-1:0]    y_lo;
    logic signed [Y_W-1:0]    y_hi;
    logic signed [Y_W-1:0]    y_sat;

    // Each stage moves when it is empty or the stage after it moves.
    assign en_out   = !out_valid_reg || !out_stall;
    assign en3      = !v3_reg || en_out;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign in_stall = !en1;
    assign accept   = in_valid && en1;

    assign cfg_ready = 1'b1;

    // Configuration writes; unknown indexes are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kp_reg      <= '0;
            ki_reg      <= '0;
            kd_reg      <= '0;
            low_reg     <= LOW_RESET;
            high_reg    <= HIGH_RESET;
            reverse_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_KP:      kp_reg      <= cfg_data[GAIN_W-1:0];
                REG_KI:      ki_reg      <= cfg_data[GAIN_W-1:0];
                REG_KD:      kd_reg      <= cfg_data[GAIN_W-1:0];
                REG_LOW:     low_reg     <= cfg_data[VAL_W-1:0];
                REG_HIGH:    high_reg    <= cfg_data[VAL_W-1:0];
                REG_REVERSE: reverse_reg <= cfg_data[0];
                default:     ;
            endcase
        end
    end

    // The smaller limit is always the lower clamp.
    always_comb
    begin
        if (low_reg < high_reg)
        begin
            lim_lo = low_reg;
            lim_hi = high_reg;
        end
        else
        begin
            lim_lo = high_reg;
            lim_hi = low_reg;
        end
    end

    // Error and measurement step; the step is zero on the manual-to-auto item.
    // Reverse action negates the operand instead of the gain.
    always_comb
    begin
        err_raw = OPD_W'(target) - OPD_W'(measurement);
        if (was_auto_reg)
        begin
            dm_raw = OPD_W'(measurement) - OPD_W'(prev_meas_reg);
        end
        else
        begin
            dm_raw = '0;
        end
        err_dir = reverse_reg ? -err_raw : err_raw;
        dm_dir  = reverse_reg ? -dm_raw : dm_raw;
    end

    // Mode tracking and stored measurement follow items in arrival order.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            was_auto_reg  <= 1'b0;
            prev_meas_reg <= '0;
        end
        else if (accept)
        begin
            was_auto_reg <= auto_mode;
            if (auto_mode)
            begin
                prev_meas_reg <= measurement;
            end
        end
    end

    // Stage 1 register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (en1)
        begin
            v1_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            err1_reg  <= err_dir;
            dm1_reg   <= dm_dir;
            man1_reg  <= manual_output;
            auto1_reg <= auto_mode;
            load1_reg <= auto_mode && !was_auto_reg;
        end
    end

    // Manual value clamped to the limits for a bumpless start.
    always_comb
    begin
        if (man1_reg > lim_hi)
        begin
            man_clamped = lim_hi;
        end
        else if (man1_reg < lim_lo)
        begin
            man_clamped = lim_lo;
        end
        else
        begin
            man_clamped = man1_reg;
        end
    end

    // Stage 2: the three gain products.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else if (en2)
        begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en2 && v1_reg)
        begin
            pprod2_reg <= PROD_W'(kp_reg) * PROD_W'(err1_reg);
            iprod2_reg <= PROD_W'(ki_reg) * PROD_W'(err1_reg);
            dprod2_reg <= PROD_W'(kd_reg) * PROD_W'(dm1_reg);
            man2_reg   <= man1_reg;
            manc2_reg  <= man_clamped;
            auto2_reg  <= auto1_reg;
            load2_reg  <= load1_reg;
        end
    end

    // Integrator update with clamping to the limits; the limits are
    // sign-extended as Q16.16 values.
    always_comb
    begin
        if (load2_reg)
        begin
            integ_base = {manc2_reg, {FRAC_W{1'b0}}};
        end
        else
        begin
            integ_base = integ_reg;
        end
        integ_sum = ISUM_W'(integ_base) + ISUM_W'(iprod2_reg);
        isum_lo   = ISUM_W'(signed'({lim_lo, {FRAC_W{1'b0}}}));
        isum_hi   = ISUM_W'(signed'({lim_hi, {FRAC_W{1'b0}}}));
        if (integ_sum > isum_hi)
        begin
            integ_next = INTEG_W'(isum_hi);
        end
        else if (integ_sum < isum_lo)
        begin
            integ_next = INTEG_W'(isum_lo);
        end
        else
        begin
            integ_next = INTEG_W'(integ_sum);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            integ_reg <= '0;
        end
        else if (en3 && v2_reg && auto2_reg)
        begin
            integ_reg <= integ_next;
        end
    end

    // Stage 3 register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
        end
        else if (en3)
        begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en3 && v2_reg)
        begin
            pd3_reg   <= PD_W'(pprod2_reg) - PD_W'(dprod2_reg);
            man3_reg  <= man2_reg;
            auto3_reg <= auto2_reg;
        end
    end

    // Output sum, saturated; the integer part is the drive value.
    always_comb
    begin
        y_sum = Y_W'(pd3_reg) + Y_W'(integ_reg);
        y_lo  = Y_W'(signed'({lim_lo, {FRAC_W{1'b0}}}));
        y_hi  = Y_W'(signed'({lim_hi, {FRAC_W{1'b0}}}));
        if (y_sum > y_hi)
        begin
            y_sat = y_hi;
        end
        else if (y_sum < y_lo)
        begin
            y_sat = y_lo;
        end
        else
        begin
            y_sat = y_sum;
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en_out)
        begin
            out_valid_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_out && v3_reg)
        begin
            computed_reg <= auto3_reg;
            if (auto3_reg)
            begin
                drive_reg <= y_sat[FRAC_W+VAL_W-1:FRAC_W];
            end
            else
            begin
                drive_reg <= man3_reg;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign drive_output = drive_reg;
    assign computed     = computed_reg;

    // A stall at the input only happens while stage 1 holds an item.
    a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> v1_reg)
        else $error("input stalled with stage 1 empty");

    // A held stage 1 item means stage 2 is occupied.
    a_hold_chain: assert property (@(posedge clk) disable iff (!rst_n)
        (v1_reg && !en2) |-> v2_reg)
        else $error("stage 1 held while stage 2 empty");

    // A freshly updated integrator lies within the limits.
    a_integ_limits: assert property (@(posedge clk) disable iff (!rst_n)
        (v3_reg && auto3_reg) |->
            (integ_reg >= INTEG_W'(signed'({lim_lo, {FRAC_W{1'b0}}})) &&
             integ_reg <= INTEG_W'(signed'({lim_hi, {FRAC_W{1'b0}}}))))
        else $error("integrator outside the limits");

    // A computed drive value lies within the limits.
    a_drive_limits: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && computed) |->
            (drive_output >= lim_lo && drive_output <= lim_hi))
        else $error("computed drive outside the limits");

endmodule

// ----- sim/pid_drive_check_pkg.sv -----
package pid_drive_check_pkg;

    import pidaw_pkg::*;

    // One controller output item as the output port presents it.
    typedef struct packed {
        logic signed [VAL_W-1:0] drive;
        logic                    computed;
    } drive_item_t;

    class pid_drive_scoreboard;

        // Register copies, as the block holds them.
        logic signed [GAIN_W-1:0] kp_reg;
        logic signed [GAIN_W-1:0] ki_reg;
        logic signed [GAIN_W-1:0] kd_reg;
        logic signed [VAL_W-1:0]  low_reg;
        logic signed [VAL_W-1:0]  high_reg;
        logic                     reverse_reg;

        // Control state: integrator in Q16.16, last measurement, mode of last sample.
        longint integ_q;
        longint last_meas;
        bit     in_auto;

        drive_item_t expected_drives[$];
        int          mismatches;

        function new();
            kp_reg      = '0;
            ki_reg      = '0;
            kd_reg      = '0;
            low_reg     = LOW_RESET;
            high_reg    = HIGH_RESET;
            reverse_reg = 1'b0;
            integ_q     = 0;
            last_meas   = 0;
            in_auto     = 1'b0;
            mismatches  = 0;
        endfunction

        function void apply_reg(logic [IDX_W-1:0] index, logic [DATA_W-1:0] data);
            case (index)
                REG_KP:      kp_reg = data[GAIN_W-1:0];
                REG_KI:      ki_reg = data[GAIN_W-1:0];
                REG_KD:      kd_reg = data[GAIN_W-1:0];
                REG_LOW:     low_reg = data[VAL_W-1:0];
                REG_HIGH:    high_reg = data[VAL_W-1:0];
                REG_REVERSE: reverse_reg = data[0];
                default:     ;
            endcase
        endfunction

        function longint clip(longint v, longint lo, longint hi);
            if (v > hi)
                return hi;
            if (v < lo)
                return lo;
            return v;
        endfunction

        function int pending();
            return expected_drives.size();
        endfunction

        // Work out the drive value that one accepted sample produces.
        function void predict_drive(logic signed [VAL_W-1:0] meas,
                                    logic signed [VAL_W-1:0] tgt,
                                    logic signed [VAL_W-1:0] manual,
                                    logic auto_on);
            longint      a, b, lo, hi, m, t, man, kp, ki, kd, err, y;
            drive_item_t item;
            a   = low_reg;
            b   = high_reg;
            m   = meas;
            t   = tgt;
            man = manual;
            // Inverted limits are swapped; equal limits pin the output.
            lo  = (a < b ? a : b) <<< FRAC_W;
            hi  = (a < b ? b : a) <<< FRAC_W;

            // Manual mode passes the manual value through and leaves the integrator and last measurement alone.
            if (!auto_on) begin
                in_auto       = 1'b0;
                item.drive    = manual;
                item.computed = 1'b0;
                expected_drives.push_back(item);
                return;
            end

            // Bumpless start on the manual-to-auto edge.
            if (!in_auto) begin
                integ_q   = clip(man <<< FRAC_W, lo, hi);
                last_meas = m;
            end
            in_auto = 1'b1;

            kp = kp_reg;
            ki = ki_reg;
            kd = kd_reg;
            if (reverse_reg) begin
                kp = -kp;
                ki = -ki;
                kd = -kd;
            end

            // Clamped integrator, derivative taken on the measurement.
            err       = t - m;
            integ_q   = clip(integ_q + ki * err, lo, hi);
            y         = clip(kp * err + integ_q - kd * (m - last_meas), lo, hi);
            last_meas = m;

            item.drive    = VAL_W'(y >>> FRAC_W);
            item.computed = 1'b1;
            expected_drives.push_back(item);
        endfunction

        // Compare one output item with the oldest prediction.
        function void check_drive(logic signed [VAL_W-1:0] drive, logic computed);
            drive_item_t want;
            if (expected_drives.size() == 0) begin
                $error("unexpected output item: drive_output %0d, computed %0d",
                       drive, computed);
                mismatches++;
                return;
            end
            want = expected_drives.pop_front();
            if (drive !== want.drive) begin
                $error("drive_output: expected %0d, actual %0d", want.drive, drive);
                mismatches++;
            end
            if (computed !== want.computed) begin
                $error("computed: expected %0d, actual %0d", want.computed, computed);
                mismatches++;
            end
        endfunction

    endclass

endpackage

// ----- sim/tb_top.sv -----
module tb_top;

    import pidaw_pkg::*;
    import pid_drive_check_pkg::*;

    localparam int IDLE_PCT     = 24;
    localparam int RANDOM_ITEMS = 1825;
    localparam int STUCK_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 8;
    localparam int CALM_PHASE   = 3;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [IDX_W-1:0]        cfg_index = '0;
    logic [DATA_W-1:0]       cfg_data = '0;
    logic                    in_valid = 1'b0;
    logic                    in_stall;
    logic signed [VAL_W-1:0] measurement = '0;
    logic signed [VAL_W-1:0] target = '0;
    logic signed [VAL_W-1:0] manual_output = '0;
    logic                    auto_mode = 1'b0;
    logic                    out_valid;
    logic                    out_stall = 1'b0;
    logic signed [VAL_W-1:0] drive_output;
    logic                    computed;

    bit                   no_idle = 1'b0;
    int                   stuck = 0;
    pid_drive_scoreboard  law = new();

    pid_controller_antiwindup dut (.*);

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // The output side stalls at random, except during the calm phase.
    always @(posedge clk)
        out_stall <= !no_idle && ($urandom_range(99) < IDLE_PCT);

    // Every accepted output item is checked against the oldest prediction.
    always @(posedge clk)
        if (rst_n && out_valid && !out_stall)
            law.check_drive(drive_output, computed);

    // Ends the run if no channel moves an item for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
            || (cfg_valid && cfg_ready))
            stuck <= 0;
        else
            stuck <= stuck + 1;
        if (stuck == STUCK_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // One register write; the caller lowers cfg_valid after its last write.
    task automatic write_reg(input logic [IDX_W-1:0] index, input logic [DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        law.apply_reg(index, data);
    endtask

    // Writes every register; unused upper data bits carry random junk.
    task automatic program_regs(input logic [GAIN_W-1:0] kp, input logic [GAIN_W-1:0] ki,
                                input logic [GAIN_W-1:0] kd, input int low, input int high,
                                input bit rev);
        logic [IDX_W-1:0] spare;
        write_reg(REG_KP, kp);
        write_reg(REG_KI, ki);
        write_reg(REG_KD, kd);
        write_reg(REG_LOW, ($urandom() & 32'hFFFF_0000) | (low & 32'h0000_FFFF));
        write_reg(REG_HIGH, ($urandom() & 32'hFFFF_0000) | (high & 32'h0000_FFFF));
        write_reg(REG_REVERSE, ($urandom() & ~32'd1) | rev);
        // Now and then an index past the register list, which must change nothing.
        if ($urandom_range(2) == 0)
        begin
            spare = IDX_W'($urandom_range(2**IDX_W - 1, int'(REG_REVERSE) + 1));
            write_reg(spare, $urandom());
        end
        cfg_valid <= 1'b0;
    endtask

    // Sends one sample item, with random idle cycles ahead of it.
    task automatic send_sample(input int meas, input int tgt, input int manual, input bit auto_on);
        while (!no_idle && $urandom_range(99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        measurement   <= VAL_W'(meas);
        target        <= VAL_W'(tgt);
        manual_output <= VAL_W'(manual);
        auto_mode     <= auto_on;
        do
            @(posedge clk);
        while (in_stall);
        law.predict_drive(measurement, target, manual_output, auto_mode);
    endtask

    // Waits until every predicted item has come out and the pipeline is empty.
    task automatic wait_drained();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (law.pending() != 0);
        repeat (4) @(posedge clk);
    endtask

    function automatic logic [GAIN_W-1:0] pick_gain();
        int g;
        case ($urandom_range(9))
            0: return '0;
            1: return 32'h8000_0000;
            2: return 32'h7FFF_FFFF;
            3, 4: return $urandom();
            default:
            begin
                // Mostly moderate gains within plus or minus four.
                g = int'($urandom_range(0, 1 << 19)) - (1 << 18);
                return g;
            end
        endcase
    endfunction

    task automatic pick_limits(output int low, output int high);
        int a, b;
        a = int'($urandom_range(0, 65535)) - 32768;
        b = int'($urandom_range(0, 65535)) - 32768;
        case ($urandom_range(9))
            0:
            begin
                low  = -32768;
                high = 32767;
            end
            1:
            begin
                // Inverted on purpose.
                low  = (a > b) ? a : b;
                high = (a > b) ? b : a;
            end
            2:
            begin
                low  = a;
                high = a;
            end
            3, 4, 5:
            begin
                low  = int'($urandom_range(0, 4000)) - 2000;
                high = low + int'($urandom_range(1, 3000));
            end
            default:
            begin
                low  = (a < b) ? a : b;
                high = (a < b) ? b : a;
            end
        endcase
    endtask

    function automatic int sat16(int v);
        if (v > 32767)
            return 32767;
        if (v < -32768)
            return -32768;
        return v;
    endfunction

    initial
    begin
        int sent, phase, len, low, high;
        int run_left, meas_cur, tgt_cur, m, t, mo;
        bit run_auto, a;
        sent     = 0;
        phase    = 0;
        run_left = 0;
        run_auto = 1'b0;
        meas_cur = 0;
        tgt_cur  = 0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: zero gains, full range, so auto tracks the loaded integrator.
        send_sample(-32768, 32767, -32768, 1'b0);
        send_sample(32767, -32768, 32767, 1'b0);
        send_sample(32767, -32768, 32767, 1'b1);
        send_sample(-32768, 32767, 0, 1'b1);
        send_sample(0, 0, 21845, 1'b0);
        send_sample(0, 0, -32768, 1'b1);

        // Plain gains with narrow limits: clamped bumpless start, saturation both ways.
        wait_drained();
        program_regs(32'h0001_0000, 32'h0000_4000, 32'h0000_8000, -1000, 1000, 1'b0);
        send_sample(0, 0, 0, 1'b0);
        send_sample(100, 200, 5000, 1'b1);
        send_sample(150, 200, 0, 1'b1);
        send_sample(-32768, 32767, 0, 1'b1);
        send_sample(32767, -32768, 0, 1'b1);
        send_sample(0, 0, 0, 1'b1);
        send_sample(0, 0, -3, 1'b0);
        send_sample(-7, 3, -5000, 1'b1);

        // Reverse acting with a negative integral gain and fractional terms.
        wait_drained();
        program_regs(32'h0000_8000, 32'hFFFF_C000, 32'h0001_8000, -20000, 20000, 1'b1);
        send_sample(10, -11, 7, 1'b1);
        send_sample(-300, 21, 7, 1'b1);
        send_sample(1234, 1234, 7, 1'b1);

        // Low limit above high limit.
        wait_drained();
        program_regs(32'h0002_0000, 32'h0000_1000, '0, 500, -500, 1'b0);
        send_sample(0, 1000, 0, 1'b1);
        send_sample(0, -1000, 0, 1'b1);

        // Equal limits pin the output.
        wait_drained();
        program_regs(32'hFFFF_0000, 32'h0001_0000, 32'h0001_0000, 123, 123, 1'b0);
        send_sample(-32768, 32767, 0, 1'b0);
        send_sample(5, -5, 9, 1'b1);

        // Extreme gains, reversed, full range.
        wait_drained();
        program_regs(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, -32768, 32767, 1'b1);
        send_sample(32767, -32768, 32767, 1'b1);
        send_sample(-32768, 32767, -32768, 1'b1);
        send_sample(0, 0, 0, 1'b1);

        // Random phases: long auto runs around a target, short manual runs, some noise.
        while (sent < RANDOM_ITEMS)
        begin
            wait_drained();
            pick_limits(low, high);
            program_regs(pick_gain(), pick_gain(), pick_gain(), low, high, $urandom_range(1));
            no_idle <= (phase == CALM_PHASE);
            len = $urandom_range(80, 200);
            // The last phase stops at the item budget.
            if (len > RANDOM_ITEMS - sent)
                len = RANDOM_ITEMS - sent;
            repeat (len)
            begin
                if (run_left == 0)
                begin
                    run_auto = ($urandom_range(99) < 80);
                    run_left = run_auto ? $urandom_range(1, 60) : $urandom_range(1, 6);
                    if ($urandom_range(1) == 0)
                        tgt_cur = int'($urandom_range(0, 65535)) - 32768;
                end
                run_left--;
                if ($urandom_range(99) < 30)
                    meas_cur = int'($urandom_range(0, 65535)) - 32768;
                else
                    meas_cur = sat16(meas_cur + int'($urandom_range(0, 400)) - 200);
                m  = meas_cur;
                t  = ($urandom_range(99) < 10) ? int'($urandom_range(0, 65535)) - 32768
                                               : tgt_cur;
                mo = ($urandom_range(1) == 0) ? int'($urandom_range(0, 65535)) - 32768
                                              : int'($urandom_range(0, 2000)) - 1000;
                a  = run_auto;
                // Noise: a sample with everything random.
                if ($urandom_range(99) < 5)
                begin
                    m  = int'($urandom_range(0, 65535)) - 32768;
                    t  = int'($urandom_range(0, 65535)) - 32768;
                    a  = $urandom_range(1);
                end
                send_sample(m, t, mo, a);
                sent++;
            end
            phase++;
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (law.mismatches == 0 && law.pending() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
